>>> rtl/core/rngc_pkg.sv
// Shared constants, types and handoff structs for the nearest-group classifier.
`timescale 1ns / 1ps

package rngc_pkg;

  localparam int GROUP_COUNT    = 4;
  localparam int TAGS_PER_GROUP = 4;
  localparam int READERS        = 4;
  localparam int RSS_W          = 16;
  localparam int DEPTH          = GROUP_COUNT * TAGS_PER_GROUP;
  localparam int ADDR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TAG_IDX_W      = (TAGS_PER_GROUP > 1) ? $clog2(TAGS_PER_GROUP) : 1;
  localparam int GRP_IDX_W      = $clog2(GROUP_COUNT);
  localparam int READER_W       = $clog2(READERS);
  localparam int SQ_W           = 2 * RSS_W;
  localparam int TAG_DIST_W     = SQ_W + $clog2(READERS);
  localparam int DIST_W         = 36;
  localparam int ACC_RAW_W      = TAG_DIST_W + $clog2(TAGS_PER_GROUP);
  localparam int ACC_W          = (ACC_RAW_W > DIST_W) ? ACC_RAW_W : DIST_W;
  localparam int SUM_W          = RSS_W + $clog2(READERS);
  localparam int TENTHS_W       = 4;
  localparam int PROD_W         = SUM_W + TENTHS_W;
  localparam int TENTHS_RESET   = 4;
  localparam int DOM_SCALE      = 10;

  typedef logic [RSS_W-1:0]                 rss_t;
  typedef logic [READERS-1:0][RSS_W-1:0]    rss_arr_t;
  typedef logic [READERS-1:0][SQ_W-1:0]     sq_arr_t;
  typedef logic [ADDR_W-1:0]                addr_t;
  typedef logic [TAG_IDX_W-1:0]             tag_idx_t;
  typedef logic [GRP_IDX_W-1:0]             grp_idx_t;
  typedef logic [1:0]                       grp_out_t;
  typedef logic [READER_W-1:0]              reader_t;
  typedef logic [SQ_W-1:0]                  sq_t;
  typedef logic [TAG_DIST_W-1:0]            tag_dist_t;
  typedef logic [ACC_W-1:0]                 acc_t;
  typedef logic [DIST_W-1:0]                dist_t;
  typedef logic [SUM_W-1:0]                 sum_t;
  typedef logic [PROD_W-1:0]                prod_t;
  typedef logic [TENTHS_W-1:0]              tenths_t;

  localparam dist_t DIST_MAX = '1;

  typedef struct packed {
    logic first_tag;
    logic last_tag;
    logic last_entry;
  } tag_info_t;

  typedef struct packed {
    logic    single;
    reader_t strongest;
  } dist_ctrl_t;

endpackage

>>> rtl/core/rfid_nearest_group_classifier.sv
// Top level: input capture, scan sequencer and output register of the classifier.
//
//   channel | direction | fields
//   in_     | input     | mode, group_sel, tag_sel, rss_reader0..3
//   out_    | output    | group_found, strongest_reader, single_reader_used, best_distance
//   cfg_    | input     | dominance_tenths (write only)
//
// A load transfer writes the store directly.
// A classify transfer picks the strongest reader, reads the store once per reference
// entry, then runs the distance and compare pipeline.
// Reset clears the store valid bits at once; no clearing pass is needed.
// in_stall is high while a classify is in progress, and at its end while the
// previous result is still stalled in the output register.
`timescale 1ns / 1ps

module rfid_nearest_group_classifier (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_mode,
  input  logic [1:0]   in_group_sel,
  input  logic [1:0]   in_tag_sel,
  input  logic [15:0]  in_rss_reader0,
  input  logic [15:0]  in_rss_reader1,
  input  logic [15:0]  in_rss_reader2,
  input  logic [15:0]  in_rss_reader3,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_group_found,
  output logic [1:0]   out_strongest_reader,
  output logic         out_single_reader_used,
  output logic [35:0]  out_best_distance
);

  typedef enum logic [1:0] {IDLE, PREP, SCAN, WAIT} state_t;

  state_t                state_r;
  rngc_pkg::tenths_t     tenths_r;
  rngc_pkg::rss_arr_t    obj_r;
  rngc_pkg::rss_arr_t    in_rss;
  rngc_pkg::dist_ctrl_t  ctrl_r;
  rngc_pkg::dist_ctrl_t  ctrl_nxt;
  rngc_pkg::addr_t       rd_cnt_r;
  rngc_pkg::tag_idx_t    tag_cnt_r;
  logic                  out_valid_r;
  rngc_pkg::grp_out_t    out_grp_r;
  rngc_pkg::reader_t     out_str_r;
  logic                  out_single_r;
  rngc_pkg::dist_t       out_dist_r;

  logic                  in_xfer;
  logic                  load_we;
  rngc_pkg::addr_t       load_addr;
  logic                  out_free;
  logic                  scan_re;
  rngc_pkg::tag_info_t   scan_info;
  logic                  ref_vld;
  rngc_pkg::rss_arr_t    ref_rss;
  rngc_pkg::tag_info_t   ref_info;
  logic                  tag_vld;
  rngc_pkg::tag_dist_t   tag_dist;
  rngc_pkg::tag_info_t   tag_info;
  logic                  sel_done;
  rngc_pkg::grp_idx_t    best_grp;
  rngc_pkg::dist_t       best_dist;

  assign in_rss   = {in_rss_reader3, in_rss_reader2, in_rss_reader1, in_rss_reader0};
  assign in_stall = (state_r != IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign load_we  = in_xfer && !in_mode
                    && (int'(in_group_sel) < rngc_pkg::GROUP_COUNT)
                    && (int'(in_tag_sel) < rngc_pkg::TAGS_PER_GROUP);
  assign load_addr = rngc_pkg::addr_t'(int'(in_group_sel) * rngc_pkg::TAGS_PER_GROUP
                                       + int'(in_tag_sel));
  assign out_free = !out_valid_r || !out_stall;

  assign scan_re              = (state_r == SCAN);
  assign scan_info.first_tag  = (tag_cnt_r == '0);
  assign scan_info.last_tag   =
    (tag_cnt_r == rngc_pkg::tag_idx_t'(rngc_pkg::TAGS_PER_GROUP - 1));
  assign scan_info.last_entry = (rd_cnt_r == rngc_pkg::addr_t'(rngc_pkg::DEPTH - 1));

  always_comb begin
    rngc_pkg::rss_t  maxv;
    rngc_pkg::sum_t  sum;
    maxv               = obj_r[0];
    sum                = '0;
    ctrl_nxt.strongest = '0;
    for (int k = 0; k < rngc_pkg::READERS; k++) begin
      if (obj_r[k] > maxv) begin
        maxv               = obj_r[k];
        ctrl_nxt.strongest = rngc_pkg::reader_t'(k);
      end
      sum = sum + rngc_pkg::sum_t'(obj_r[k]);
    end
    ctrl_nxt.single = (rngc_pkg::prod_t'(maxv) * rngc_pkg::prod_t'(rngc_pkg::DOM_SCALE))
                      > (rngc_pkg::prod_t'(tenths_r) * rngc_pkg::prod_t'(sum));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      tenths_r    <= rngc_pkg::tenths_t'(rngc_pkg::TENTHS_RESET);
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
      tag_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        tenths_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && !((state_r == WAIT) && sel_done)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_xfer && in_mode) begin
            obj_r   <= in_rss;
            state_r <= PREP;
          end
        end
        PREP: begin
          ctrl_r    <= ctrl_nxt;
          rd_cnt_r  <= '0;
          tag_cnt_r <= '0;
          state_r   <= SCAN;
        end
        SCAN: begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
          if (scan_info.last_tag) begin
            tag_cnt_r <= '0;
          end else begin
            tag_cnt_r <= tag_cnt_r + 1'b1;
          end
          if (scan_info.last_entry) begin
            state_r <= WAIT;
          end
        end
        WAIT: begin
          if (sel_done && out_free) begin
            out_valid_r  <= 1'b1;
            out_grp_r    <= rngc_pkg::grp_out_t'(best_grp);
            out_str_r    <= ctrl_r.strongest;
            out_single_r <= ctrl_r.single;
            out_dist_r   <= best_dist;
            state_r      <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  rngc_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .we        (load_we),
    .waddr     (load_addr),
    .wdata     (in_rss),
    .re        (scan_re),
    .raddr     (rd_cnt_r),
    .rinfo     (scan_info),
    .rvalid    (ref_vld),
    .rdata     (ref_rss),
    .rinfo_out (ref_info)
  );

  rngc_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ref_vld  (ref_vld),
    .ref_rss  (ref_rss),
    .ref_info (ref_info),
    .obj_rss  (obj_r),
    .ctrl     (ctrl_r),
    .tag_vld  (tag_vld),
    .tag_dist (tag_dist),
    .tag_info (tag_info)
  );

  rngc_sel u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == PREP),
    .tag_vld   (tag_vld),
    .tag_dist  (tag_dist),
    .tag_info  (tag_info),
    .done      (sel_done),
    .best_grp  (best_grp),
    .best_dist (best_dist)
  );

  assign out_valid              = out_valid_r;
  assign out_group_found        = out_grp_r;
  assign out_strongest_reader   = out_str_r;
  assign out_single_reader_used = out_single_r;
  assign out_best_distance      = out_dist_r;

endmodule

>>> rtl/core/rngc_store.sv
// Reference store: 64-bit entries with per-entry valid bits, registered read.
`timescale 1ns / 1ps

module rngc_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  rngc_pkg::addr_t       waddr,
  input  rngc_pkg::rss_arr_t    wdata,
  input  logic                  re,
  input  rngc_pkg::addr_t       raddr,
  input  rngc_pkg::tag_info_t   rinfo,
  output logic                  rvalid,
  output rngc_pkg::rss_arr_t    rdata,
  output rngc_pkg::tag_info_t   rinfo_out
);

  rngc_pkg::rss_arr_t              mem_r [rngc_pkg::DEPTH];
  logic [rngc_pkg::DEPTH-1:0]      valid_r;
  rngc_pkg::rss_arr_t              rdata_r;
  rngc_pkg::tag_info_t             rinfo_r;
  logic                            rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= valid_r[raddr] ? mem_r[raddr] : '0;
      rinfo_r <= rinfo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= re;
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  assign rvalid    = rvalid_r;
  assign rdata     = rdata_r;
  assign rinfo_out = rinfo_r;

endmodule

>>> rtl/core/rngc_dist.sv
// Per-tag distance: registered squared differences, then registered lane sum.
`timescale 1ns / 1ps

module rngc_dist (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ref_vld,
  input  rngc_pkg::rss_arr_t    ref_rss,
  input  rngc_pkg::tag_info_t   ref_info,
  input  rngc_pkg::rss_arr_t    obj_rss,
  input  rngc_pkg::dist_ctrl_t  ctrl,
  output logic                  tag_vld,
  output rngc_pkg::tag_dist_t   tag_dist,
  output rngc_pkg::tag_info_t   tag_info
);

  rngc_pkg::sq_arr_t    sq_nxt;
  rngc_pkg::sq_arr_t    sq_r;
  logic                 sq_vld_r;
  rngc_pkg::tag_info_t  sq_info_r;
  rngc_pkg::tag_dist_t  tag_dist_nxt;
  rngc_pkg::tag_dist_t  tag_dist_r;
  logic                 tag_vld_r;
  rngc_pkg::tag_info_t  tag_info_r;

  always_comb begin
    rngc_pkg::rss_t d;
    for (int k = 0; k < rngc_pkg::READERS; k++) begin
      d = (obj_rss[k] > ref_rss[k]) ? (obj_rss[k] - ref_rss[k]) : (ref_rss[k] - obj_rss[k]);
      if (ctrl.single && (rngc_pkg::reader_t'(k) != ctrl.strongest)) begin
        sq_nxt[k] = '0;
      end else begin
        sq_nxt[k] = rngc_pkg::sq_t'(d) * rngc_pkg::sq_t'(d);
      end
    end
  end

  always_comb begin
    tag_dist_nxt = '0;
    for (int k = 0; k < rngc_pkg::READERS; k++) begin
      tag_dist_nxt = tag_dist_nxt + rngc_pkg::tag_dist_t'(sq_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ref_vld) begin
      sq_r      <= sq_nxt;
      sq_info_r <= ref_info;
    end
    if (sq_vld_r) begin
      tag_dist_r <= tag_dist_nxt;
      tag_info_r <= sq_info_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      tag_vld_r <= 1'b0;
    end else begin
      sq_vld_r  <= ref_vld;
      tag_vld_r <= sq_vld_r;
    end
  end

  assign tag_vld  = tag_vld_r;
  assign tag_dist = tag_dist_r;
  assign tag_info = tag_info_r;

endmodule

>>> rtl/core/rngc_sel.sv
// Group accumulation with saturation, then running minimum over complete groups.
`timescale 1ns / 1ps

module rngc_sel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  tag_vld,
  input  rngc_pkg::tag_dist_t   tag_dist,
  input  rngc_pkg::tag_info_t   tag_info,
  output logic                  done,
  output rngc_pkg::grp_idx_t    best_grp,
  output rngc_pkg::dist_t       best_dist
);

  rngc_pkg::acc_t      acc_r;
  rngc_pkg::acc_t      sum_nxt;
  rngc_pkg::dist_t     grp_dist_r;
  logic                grp_vld_r;
  logic                grp_last_r;
  rngc_pkg::grp_idx_t  grp_cnt_r;
  rngc_pkg::grp_idx_t  best_grp_r;
  rngc_pkg::dist_t     best_r;
  logic                done_r;

  assign sum_nxt = (tag_info.first_tag ? '0 : acc_r) + rngc_pkg::acc_t'(tag_dist);

  always_ff @(posedge clk) begin
    if (tag_vld) begin
      acc_r      <= sum_nxt;
      grp_last_r <= tag_info.last_entry;
      if (sum_nxt > rngc_pkg::acc_t'(rngc_pkg::DIST_MAX)) begin
        grp_dist_r <= rngc_pkg::DIST_MAX;
      end else begin
        grp_dist_r <= rngc_pkg::dist_t'(sum_nxt);
      end
    end
    if (grp_vld_r && ((grp_cnt_r == '0) || (grp_dist_r < best_r))) begin
      best_r     <= grp_dist_r;
      best_grp_r <= grp_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      grp_cnt_r <= '0;
      done_r    <= 1'b0;
    end else begin
      grp_vld_r <= tag_vld && tag_info.last_tag;
      if (start) begin
        grp_cnt_r <= '0;
        done_r    <= 1'b0;
      end else if (grp_vld_r) begin
        grp_cnt_r <= grp_cnt_r + 1'b1;
        if (grp_last_r) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign best_grp  = best_grp_r;
  assign best_dist = best_r;

endmodule

>>> rtl/core/rngc_checker.sv
// Port-level checker for the classifier, bound to the top level.
`timescale 1ns / 1ps

module rngc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_stall,
  input  logic         in_mode,
  input  logic         out_valid,
  input  logic         out_stall,
  input  logic [1:0]   out_group_found,
  input  logic [35:0]  out_best_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_best_distance) && $stable(out_group_found))
    else $error("stalled result changed");

  a_load_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode |=> !in_stall)
    else $error("load transfer blocked the input");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> in_stall && !$rose(out_valid))
    else $error("classify transfer did not occupy the block");

endmodule

bind rfid_nearest_group_classifier rngc_checker u_rngc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_mode           (in_mode),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_group_found   (out_group_found),
  .out_best_distance (out_best_distance)
);

>>> bench/rfid_nearest_group_classifier_test.sv
// Self-checking testbench for the nearest-group RSSI fingerprint classifier.
`timescale 1ns / 1ps

module rfid_nearest_group_classifier_test;
  import rngc_pkg::*;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   CYCLE_LIMIT   = 500000;
  localparam int   PHASE_ITEMS   = 108;

  typedef struct packed {
    logic       mode;
    logic [1:0] group_sel;
    logic [1:0] tag_sel;
    rss_arr_t   rss;
  } scan_item_t;

  typedef struct packed {
    grp_out_t grp;
    reader_t  strongest;
    logic     single;
    dist_t    distance;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_LOAD;
  logic [1:0]  in_group_sel = '0;
  logic [1:0]  in_tag_sel = '0;
  logic [15:0] in_rss_reader0 = '0;
  logic [15:0] in_rss_reader1 = '0;
  logic [15:0] in_rss_reader2 = '0;
  logic [15:0] in_rss_reader3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_group_found;
  logic [1:0]  out_strongest_reader;
  logic        out_single_reader_used;
  logic [35:0] out_best_distance;

  rfid_nearest_group_classifier dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_mode                (in_mode),
    .in_group_sel           (in_group_sel),
    .in_tag_sel             (in_tag_sel),
    .in_rss_reader0         (in_rss_reader0),
    .in_rss_reader1         (in_rss_reader1),
    .in_rss_reader2         (in_rss_reader2),
    .in_rss_reader3         (in_rss_reader3),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_group_found        (out_group_found),
    .out_strongest_reader   (out_strongest_reader),
    .out_single_reader_used (out_single_reader_used),
    .out_best_distance      (out_best_distance)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rss_arr_t   fingerprint_db [DEPTH];
  tenths_t    share_tenths = tenths_t'(TENTHS_RESET);
  scan_item_t pending_items [$];
  verdict_t   verdicts_due [$];
  scan_item_t held_item;
  int         errors = 0;
  int         cycles = 0;
  int         n_loads = 0;
  int         n_classifies = 0;
  int         n_single = 0;
  int         n_checked = 0;
  int         n_settings = 0;
  int         in_idle_left = 0;
  int         out_hold_left = 0;
  bit         in_calm = 1'b0;
  bit         out_calm = 1'b0;

  initial begin
    for (int i = 0; i < DEPTH; i++) fingerprint_db[i] = '0;
  end

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic rss_arr_t quad(rss_t a0, rss_t a1, rss_t a2, rss_t a3);
    return {a3, a2, a1, a0};
  endfunction

  function automatic rss_t rand_rss();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return rss_t'($urandom_range(0, 255));
      3: return rss_t'(16'hFFFF - $urandom_range(0, 255));
      default: return rss_t'($urandom);
    endcase
  endfunction

  function automatic verdict_t nearest_group_of(rss_arr_t obj);
    verdict_t        v;
    longint unsigned maxv, total, grp_sum, best, a, b, d;
    reader_t         top;
    logic            single;
    int              idx;
    top = '0;
    maxv = obj[0];
    total = 0;
    best = 0;
    v = '0;
    for (int k = 0; k < READERS; k++) begin
      if (obj[k] > maxv) begin
        maxv = obj[k];
        top = reader_t'(k);
      end
      total += obj[k];
    end
    single = (10 * maxv) > (longint'(share_tenths) * total);
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_sum = 0;
      for (int t = 0; t < TAGS_PER_GROUP; t++) begin
        idx = g * TAGS_PER_GROUP + t;
        for (int k = 0; k < READERS; k++) begin
          if (!single || k == int'(top)) begin
            a = fingerprint_db[idx][k];
            b = obj[k];
            d = (a > b) ? a - b : b - a;
            grp_sum += d * d;
          end
        end
      end
      if (grp_sum > DIST_MAX) grp_sum = DIST_MAX;
      if (g == 0 || grp_sum < best) begin
        best = grp_sum;
        v.grp = grp_out_t'(g);
      end
    end
    v.strongest = top;
    v.single = single;
    v.distance = dist_t'(best);
    return v;
  endfunction

  function automatic void absorb_item(scan_item_t it);
    verdict_t v;
    if (it.mode == MODE_LOAD) begin
      if (it.group_sel < GROUP_COUNT && it.tag_sel < TAGS_PER_GROUP)
        fingerprint_db[int'(it.group_sel) * TAGS_PER_GROUP + int'(it.tag_sel)] = it.rss;
      n_loads++;
    end else begin
      v = nearest_group_of(it.rss);
      verdicts_due.push_back(v);
      n_classifies++;
      if (v.single) n_single++;
    end
  endfunction

  function automatic void push_item(logic mode, logic [1:0] g, logic [1:0] t, rss_arr_t r);
    scan_item_t it;
    it.mode = mode;
    it.group_sel = g;
    it.tag_sel = t;
    it.rss = r;
    pending_items.push_back(it);
  endfunction

  // Loads and lookups, half near stored fingerprints, plus dominant-reader, equal-reading and noise items.
  task automatic queue_random(int count);
    scan_item_t it;
    rss_arr_t   base;
    int         top;
    for (int i = 0; i < count; i++) begin
      it.mode = ($urandom_range(0, 99) < 40) ? MODE_CLASSIFY : MODE_LOAD;
      it.group_sel = 2'($urandom_range(0, 3));
      it.tag_sel = 2'($urandom_range(0, 3));
      base = fingerprint_db[$urandom_range(0, DEPTH - 1)];
      top = $urandom_range(0, READERS - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int k = 0; k < READERS; k++)
            it.rss[k] = base[k] + rss_t'($urandom_range(0, 64)) - rss_t'(32);
        end
        4: it.rss = base;
        5, 6: begin
          for (int k = 0; k < READERS; k++)
            it.rss[k] = rss_t'($urandom_range(0, 4000));
          it.rss[top] = rss_t'($urandom_range(2000, 65535));
        end
        7: begin
          it.rss[0] = rand_rss();
          for (int k = 1; k < READERS; k++) it.rss[k] = it.rss[0];
        end
        default: begin
          for (int k = 0; k < READERS; k++) it.rss[k] = rand_rss();
        end
      endcase
      pending_items.push_back(it);
    end
  endtask

  task automatic quiesce();
    while (pending_items.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_share(tenths_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    share_tenths = v;
    n_settings++;
  endtask

  // Input side: one transfer per edge with valid high and stall low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        absorb_item(held_item);
        in_idle_left = pick_gap(in_calm);
      end
      if (!in_valid || !in_stall) begin
        if (in_idle_left == 0 && pending_items.size() > 0) begin
          held_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= held_item.mode;
          in_group_sel <= held_item.group_sel;
          in_tag_sel <= held_item.tag_sel;
          in_rss_reader0 <= held_item.rss[0];
          in_rss_reader1 <= held_item.rss[1];
          in_rss_reader2 <= held_item.rss[2];
          in_rss_reader3 <= held_item.rss[3];
        end else begin
          in_valid <= 1'b0;
          if (in_idle_left > 0) in_idle_left--;
        end
      end
    end
  end

  // Result side: check each transfer against the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result group %0d dist %0d", $time,
                   out_group_found, out_best_distance);
          errors++;
        end else begin
          v = verdicts_due.pop_front();
          n_checked++;
          if (out_group_found !== v.grp) begin
            $display("%0t: group_found expected %0d actual %0d", $time,
                     v.grp, out_group_found);
            errors++;
          end
          if (out_strongest_reader !== v.strongest) begin
            $display("%0t: strongest_reader expected %0d actual %0d", $time,
                     v.strongest, out_strongest_reader);
            errors++;
          end
          if (out_single_reader_used !== v.single) begin
            $display("%0t: single_reader_used expected %0d actual %0d", $time,
                     v.single, out_single_reader_used);
            errors++;
          end
          if (out_best_distance !== v.distance) begin
            $display("%0t: best_distance expected %0d actual %0d", $time,
                     v.distance, out_best_distance);
            errors++;
          end
        end
        out_hold_left = pick_gap(out_calm);
      end else if (out_hold_left > 0) begin
        out_hold_left--;
      end
      out_stall <= (out_hold_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
               verdicts_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store, all-zero and full-scale readings, ties and dominant readers.
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    push_item(MODE_CLASSIFY, 2'd3, 2'd3, quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(MODE_LOAD, 2'd3, 2'd3, quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(MODE_LOAD, 2'd2, 2'd1, quad(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA));
    push_item(MODE_LOAD, 2'd1, 2'd2, quad(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE));
    push_item(MODE_LOAD, 2'd0, 2'd0, quad(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    push_item(MODE_LOAD, 2'd1, 2'd0, quad(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0));
    push_item(MODE_LOAD, 2'd2, 2'd3, quad(16'hAAAA, 16'h5555, 16'hABCD, 16'h1234));
    push_item(MODE_CLASSIFY, 2'd1, 2'd2, quad(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    push_item(MODE_CLASSIFY, 2'd2, 2'd1, quad(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'd100, 16'd100, 16'd100, 16'd100));
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'd5, 16'd9, 16'd9, 16'd1));
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA));
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'h0000, 16'h0000, 16'h0001, 16'h0000));
    push_item(MODE_LOAD, 2'd0, 2'd0, quad(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    push_item(MODE_CLASSIFY, 2'd0, 2'd0, quad(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    queue_random(PHASE_ITEMS / 2);

    quiesce();
    set_share(tenths_t'(0));
    queue_random(PHASE_ITEMS);
    quiesce();
    set_share(tenths_t'(10));
    queue_random(PHASE_ITEMS);
    quiesce();
    set_share(tenths_t'(15));
    queue_random(PHASE_ITEMS);
    quiesce();
    set_share(tenths_t'(1));
    queue_random(PHASE_ITEMS / 2);
    quiesce();
    set_share(tenths_t'($urandom_range(2, 9)));
    queue_random(PHASE_ITEMS);
    quiesce();

    $display("covered %0d loads and %0d lookups (%0d single-reader), %0d results checked",
             n_loads, n_classifies, n_single, n_checked);
    $display("across %0d threshold settings plus the reset value, %0d mismatches",
             n_settings, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> rfid_nearest_group_classifier.f
rtl/core/rngc_pkg.sv
rtl/core/rngc_store.sv
rtl/core/rngc_dist.sv
rtl/core/rngc_sel.sv
rtl/core/rfid_nearest_group_classifier.sv
rtl/core/rngc_checker.sv
bench/rfid_nearest_group_classifier_test.sv
